### src/gpfa_pkg.sv
// types and constants for the gravity pair force accumulator
// no dependencies
`default_nettype none

package gpfa_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_NORM,
    S_NSHIFT,
    S_SQRT,
    S_DIV,
    S_SCALE,
    S_SUM
  } state_t;

  // multiply steps, in issue order
  typedef enum logic [4:0] {
    ST_SQX, ST_SQY, ST_SQZ,
    ST_QQ, ST_Q3, ST_MM, ST_GKL, ST_GKH, ST_A1L, ST_A1H,
    ST_X0, ST_X1, ST_X2,
    ST_Y0, ST_Y1, ST_Y2,
    ST_Z0, ST_Z1, ST_Z2
  } step_t;

  // G * 1e12 in Q24
  localparam logic [31:0] GK_Q24      = 32'd1119761727;
  localparam logic [31:0] SOFT_RESET  = 32'd4;
  localparam logic [63:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;
  // upper half of 2^63-1, the first partial remainder of the division
  localparam logic [63:0] DIV_REM0    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [4:0]  DIV_LAST    = 5'd31;
  // output shift is 93 + 3e, counted from an 8-bit pre-shift
  localparam logic [6:0]  SH_E1       = 7'd96;
  localparam logic [6:0]  SH_E0       = 7'd93;
  localparam logic [6:0]  SH_STEP     = 7'd3;
  localparam logic [63:0] FORCE_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FORCE_MIN   = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

### src/gravity_pair_force_accumulator.sv
// softened gravity pair force with running source sums, top level
// depends on gpfa_pkg
`default_nettype none

// one word in carries a source and a target body; one word out carries the
// target's reaction force, the source force sums after this pair and a done
// flag copied from last_target (the sums are cleared after that word). all
// arithmetic runs through one shared 32x32 multiplier under a step sequencer,
// with a bit-a-cycle square root and a bit-a-cycle divider beside it.
// an item runs through 19 multiplies (multiply, then accumulate): the three
// squares, then one normalise step and, when the softened squared distance
// is below 2^64, k (0..31) 2-bit normalising shifts and one shift check, then
// 32 square root steps, 32 division steps, the remaining multiplies with three
// scale steps among them, and a last step to load the output register.
// coincident bodies with no softening skip from the normalise step to the
// output register. a full output register holds the block in its sum state
// until the word is taken. in_ready is high only while idle; a finished
// result sits in the output register so the next word can be taken while it
// waits.
module gravity_pair_force_accumulator
  import gpfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_source_x,
  input  wire logic signed [31:0] in_source_y,
  input  wire logic signed [31:0] in_source_z,
  input  wire logic [23:0]        in_source_mass,
  input  wire logic signed [31:0] in_target_x,
  input  wire logic signed [31:0] in_target_y,
  input  wire logic signed [31:0] in_target_z,
  input  wire logic [23:0]        in_target_mass,
  input  wire logic               in_last_target,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      out_reaction_fx,
  output logic signed [63:0]      out_reaction_fy,
  output logic signed [63:0]      out_reaction_fz,
  output logic signed [63:0]      out_source_sum_fx,
  output logic signed [63:0]      out_source_sum_fy,
  output logic signed [63:0]      out_source_sum_fz,
  output logic                    out_source_done
);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [31:0]  soft_r;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  prod_r, prod_nxt;
  logic [31:0]  ud_r [3];
  logic [31:0]  ud_nxt [3];
  logic [2:0]   neg_r, neg_nxt;
  logic [23:0]  ms_r, ms_nxt, mt_r, mt_nxt;
  logic         last_r, last_nxt;
  logic [63:0]  n_r, n_nxt;
  logic [63:0]  res_r, res_nxt;
  logic [63:0]  bit_r, bit_nxt;
  logic [31:0]  q_r, q_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic [6:0]   sh_r, sh_nxt;
  logic [31:0]  q3_r, q3_nxt;
  logic [15:0]  mmh_r, mmh_nxt;
  logic [30:0]  a1h_r, a1h_nxt;
  logic [94:0]  g2_r, g2_nxt;
  logic [63:0]  pair_r [3];
  logic [63:0]  pair_nxt [3];
  logic [63:0]  sum_r [3];
  logic [63:0]  sum_nxt [3];
  logic [63:0]  orx_r, ory_r, orz_r, osx_r, osy_r, osz_r;
  logic [63:0]  orx_nxt, ory_nxt, orz_nxt, osx_nxt, osy_nxt, osz_nxt;
  logic         odone_r, odone_nxt;
  logic         ovalid_r, ovalid_nxt;

  // shared multiplier operands and accumulate control
  logic [31:0]  mul_a, mul_b;
  logic [1:0]   mul_limb;
  logic         mul_clr;

  logic         out_free;
  assign out_free = !ovalid_r || out_ready;

  // ---------------------------------------------------------------------
  // step decode: operands, limb offset and whether the sum restarts
  always_comb begin
    mul_a    = ud_r[0];
    mul_b    = ud_r[0];
    mul_limb = 2'd0;
    mul_clr  = 1'b0;
    unique case (step_r)
      ST_SQX: begin mul_a = ud_r[0]; mul_b = ud_r[0]; end
      ST_SQY: begin mul_a = ud_r[1]; mul_b = ud_r[1]; end
      ST_SQZ: begin mul_a = ud_r[2]; mul_b = ud_r[2]; end
      ST_QQ:  begin mul_a = q_r; mul_b = q_r; mul_clr = 1'b1; end
      ST_Q3:  begin mul_a = acc_r[63:32]; mul_b = q_r; mul_clr = 1'b1; end
      ST_MM:  begin
        mul_a = {8'd0, ms_r}; mul_b = {8'd0, mt_r}; mul_clr = 1'b1;
      end
      ST_GKL: begin mul_a = acc_r[31:0]; mul_b = GK_Q24; mul_clr = 1'b1; end
      ST_GKH: begin mul_a = {16'd0, mmh_r}; mul_b = GK_Q24; mul_limb = 2'd1; end
      ST_A1L: begin mul_a = acc_r[47:16]; mul_b = q3_r; mul_clr = 1'b1; end
      ST_A1H: begin mul_a = {1'b0, a1h_r}; mul_b = q3_r; mul_limb = 2'd1; end
      ST_X0:  begin mul_a = acc_r[31:0]; mul_b = ud_r[0]; mul_clr = 1'b1; end
      ST_X1:  begin mul_a = g2_r[63:32]; mul_b = ud_r[0]; mul_limb = 2'd1; end
      ST_X2:  begin mul_a = {1'b0, g2_r[94:64]}; mul_b = ud_r[0]; mul_limb = 2'd2; end
      ST_Y0:  begin mul_a = g2_r[31:0]; mul_b = ud_r[1]; mul_clr = 1'b1; end
      ST_Y1:  begin mul_a = g2_r[63:32]; mul_b = ud_r[1]; mul_limb = 2'd1; end
      ST_Y2:  begin mul_a = {1'b0, g2_r[94:64]}; mul_b = ud_r[1]; mul_limb = 2'd2; end
      ST_Z0:  begin mul_a = g2_r[31:0]; mul_b = ud_r[2]; mul_clr = 1'b1; end
      ST_Z1:  begin mul_a = g2_r[63:32]; mul_b = ud_r[2]; mul_limb = 2'd1; end
      ST_Z2:  begin mul_a = {1'b0, g2_r[94:64]}; mul_b = ud_r[2]; mul_limb = 2'd2; end
      default: begin mul_a = ud_r[0]; mul_b = ud_r[0]; end
    endcase
  end

  // ---------------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_ADD;
      S_ADD: begin
        priority if (step_r == ST_SQZ) state_nxt = S_NORM;
        else if (step_r == ST_X2 || step_r == ST_Y2 || step_r == ST_Z2)
          state_nxt = S_SCALE;
        else state_nxt = S_MUL;
      end
      S_NORM: begin
        priority if (acc_r[65:0] == 66'd0) state_nxt = S_SUM;
        else if (acc_r[65:64] != 2'd0) state_nxt = S_SQRT;
        else state_nxt = S_NSHIFT;
      end
      S_NSHIFT: if (n_r[63:62] != 2'd0) state_nxt = S_SQRT;
      S_SQRT:   if (bit_r[0]) state_nxt = S_DIV;
      S_DIV:    if (cnt_r == DIV_LAST) state_nxt = S_MUL;
      S_SCALE:  state_nxt = (step_r == ST_Z2) ? S_SUM : S_MUL;
      S_SUM:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath
  logic signed [32:0] d_in [3];
  logic [63:0]  sq_try;
  logic [32:0]  div_try;
  logic [134:0] scaled;
  logic [62:0]  mag;
  logic [1:0]   comp;
  logic [64:0]  sum_wide [3];

  always_comb begin
    d_in[0] = {in_target_x[31], in_target_x} - {in_source_x[31], in_source_x};
    d_in[1] = {in_target_y[31], in_target_y} - {in_source_y[31], in_source_y};
    d_in[2] = {in_target_z[31], in_target_z} - {in_source_z[31], in_source_z};

    sq_try  = res_r + bit_r;
    div_try = {n_r[31:0], 1'b1};

    // (p << 8) >> (93 + 3e), saturated to 63 bits of magnitude
    scaled = {acc_r[126:0], 8'd0} >> sh_r;
    mag    = (scaled[134:63] != 72'd0) ? FORCE_MAX[62:0] : scaled[62:0];
    comp   = (step_r == ST_X2) ? 2'd0 : ((step_r == ST_Y2) ? 2'd1 : 2'd2);

    for (int i = 0; i < 3; i++) begin
      sum_wide[i] = {sum_r[i][63], sum_r[i]} + {pair_r[i][63], pair_r[i]};
    end

    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    ud_nxt   = ud_r;
    neg_nxt  = neg_r;
    ms_nxt   = ms_r;
    mt_nxt   = mt_r;
    last_nxt = last_r;
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    q3_nxt   = q3_r;
    mmh_nxt  = mmh_r;
    a1h_nxt  = a1h_r;
    g2_nxt   = g2_r;
    pair_nxt = pair_r;
    sum_nxt  = sum_r;
    step_nxt = step_r;
    orx_nxt  = orx_r;
    ory_nxt  = ory_r;
    orz_nxt  = orz_r;
    osx_nxt  = osx_r;
    osy_nxt  = osy_r;
    osz_nxt  = osz_r;
    odone_nxt  = odone_r;
    ovalid_nxt = ovalid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          for (int i = 0; i < 3; i++) begin
            neg_nxt[i] = d_in[i][32];
            ud_nxt[i]  = d_in[i][32] ? 32'(-d_in[i]) : d_in[i][31:0];
          end
          ms_nxt   = in_source_mass;
          mt_nxt   = in_target_mass;
          last_nxt = in_last_target;
          acc_nxt  = {96'd0, soft_r};
          step_nxt = ST_SQX;
        end
      end
      S_MUL: begin
        prod_nxt = mul_a * mul_b;
        // pick up partial results before the accumulator moves on
        unique case (step_r)
          ST_MM:   q3_nxt  = acc_r[63:32];
          ST_GKL:  mmh_nxt = acc_r[47:32];
          ST_A1L:  a1h_nxt = acc_r[78:48];
          ST_X0:   g2_nxt  = acc_r[94:0];
          default: ;
        endcase
      end
      S_ADD: begin
        acc_nxt = (mul_clr ? 128'd0 : acc_r) + ({64'd0, prod_r} << {mul_limb, 5'd0});
        if (step_r != ST_SQZ && step_r != ST_X2 && step_r != ST_Y2 && step_r != ST_Z2)
          step_nxt = step_t'(step_r + 5'd1);
      end
      S_NORM: begin
        res_nxt = 64'd0;
        bit_nxt = SQRT_BIT0;
        if (acc_r[65:64] != 2'd0) begin
          n_nxt  = acc_r[65:2];
          sh_nxt = SH_E1;
        end else begin
          n_nxt  = acc_r[63:0];
          sh_nxt = SH_E0;
        end
        // coincident bodies with no softening: no force
        if (acc_r[65:0] == 66'd0) begin
          for (int i = 0; i < 3; i++) pair_nxt[i] = 64'd0;
        end
      end
      S_NSHIFT: begin
        if (n_r[63:62] == 2'd0) begin
          n_nxt  = {n_r[61:0], 2'd0};
          sh_nxt = sh_r - SH_STEP;
        end
      end
      S_SQRT: begin
        if (n_r >= sq_try) begin
          n_nxt   = n_r - sq_try;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          n_nxt   = DIV_REM0;
          cnt_nxt = 5'd0;
        end
      end
      S_DIV: begin
        // restoring division of 2^63-1 by the root, one quotient bit a cycle
        if (div_try >= {1'b0, res_r[31:0]}) begin
          n_nxt = {32'd0, 32'(div_try - {1'b0, res_r[31:0]})};
          q_nxt = {q_r[30:0], 1'b1};
        end else begin
          n_nxt = {32'd0, div_try[31:0]};
          q_nxt = {q_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) step_nxt = ST_QQ;
      end
      S_SCALE: begin
        pair_nxt[comp] = neg_r[comp] ? -{1'b0, mag} : {1'b0, mag};
        if (step_r != ST_Z2) step_nxt = step_t'(step_r + 5'd1);
      end
      S_SUM: begin
        if (out_free) begin
          for (int i = 0; i < 3; i++) begin
            priority if (sum_wide[i][64] != sum_wide[i][63])
              sum_nxt[i] = sum_wide[i][64] ? FORCE_MIN : FORCE_MAX;
            else
              sum_nxt[i] = sum_wide[i][63:0];
          end
          orx_nxt = -pair_r[0];
          ory_nxt = -pair_r[1];
          orz_nxt = -pair_r[2];
          osx_nxt = sum_nxt[0];
          osy_nxt = sum_nxt[1];
          osz_nxt = sum_nxt[2];
          odone_nxt  = last_r;
          ovalid_nxt = 1'b1;
          // sums restart after the source's final target
          if (last_r) begin
            for (int i = 0; i < 3; i++) sum_nxt[i] = 64'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= ST_SQX;
      soft_r   <= SOFT_RESET;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= 64'd0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
      sum_r    <= sum_nxt;
      if (cfg_we) soft_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    ud_r    <= ud_nxt;
    neg_r   <= neg_nxt;
    ms_r    <= ms_nxt;
    mt_r    <= mt_nxt;
    last_r  <= last_nxt;
    n_r     <= n_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    sh_r    <= sh_nxt;
    q3_r    <= q3_nxt;
    mmh_r   <= mmh_nxt;
    a1h_r   <= a1h_nxt;
    g2_r    <= g2_nxt;
    pair_r  <= pair_nxt;
    orx_r   <= orx_nxt;
    ory_r   <= ory_nxt;
    orz_r   <= orz_nxt;
    osx_r   <= osx_nxt;
    osy_r   <= osy_nxt;
    osz_r   <= osz_nxt;
    odone_r <= odone_nxt;
  end

  // ports
  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = ovalid_r;
  assign out_reaction_fx   = orx_r;
  assign out_reaction_fy   = ory_r;
  assign out_reaction_fz   = orz_r;
  assign out_source_sum_fx = osx_r;
  assign out_source_sum_fy = osy_r;
  assign out_source_sum_fz = osz_r;
  assign out_source_done   = odone_r;

endmodule

`default_nettype wire
